/* hw/rtl/wrms_pkg.sv */
// Shared types and constants of the windowed RMS meter.
// No dependencies; every other file imports this package.
package wrms_pkg;

  localparam int SAMPLE_W = 18;
  localparam int WLEN_W   = 13;
  localparam int OFFS_W   = 18;
  localparam int SUM_W    = 47;
  localparam int ADD_W    = 25;
  localparam int RMS_W    = 26;
  localparam int DIFF_W   = 20;
  localparam int MAG_W    = 19;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int MEAN_W   = 64;
  localparam int ROOT_W   = 32;
  localparam int CFG_DW   = 64;
  localparam int CFG_AW   = 6;

  localparam int DEF_SAMPLE_BITS = 18;
  localparam int DEF_MAX_WINDOW  = 4096;
  localparam int DEF_FRAC_BITS   = 8;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 13'd256;
  localparam logic [RMS_W-1:0]  RMS_MAX    = '1;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_WINDOW = 3'd1,
    REG_OFFSET = 3'd2,
    REG_GATE   = 3'd3,
    REG_ADD    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              mode;
    logic [WLEN_W-1:0] window_length;
    logic [OFFS_W-1:0] offset_counts;
    logic [SUM_W-1:0]  gate_threshold;
    logic [ADD_W-1:0]  post_root_add;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic square;
    logic accum;
    logic div_init;
    logic div_step;
    logic root_init;
    logic root_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic win_end;
    logic div_last;
    logic root_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* hw/rtl/wrms_if.sv */
// Valid/ready channels of the windowed RMS meter: sample in, result out.
// Depends on wrms_pkg.
interface wrms_in_if;
  import wrms_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wrms_out_if;
  import wrms_pkg::*;
  logic             valid;
  logic             ready;
  logic [RMS_W-1:0] rms_value;
  logic             gated;
  modport source (output valid, output rms_value, output gated, input ready);
  modport sink   (input valid, input rms_value, input gated, output ready);
endinterface

/* hw/rtl/windowed_rms_meter.sv */
// Windowed true-RMS meter, top level. Depends on wrms_pkg, wrms_if and submodules.
// Samples are taken one at a time: offset/square, multiply and accumulate finish before the next is accepted.
// Window end: after the edge accepting the last sample, the divider and then the root run
//   before the edge loading the result register.
// A result waits in the output register; the next window end stalls until it is taken.
// Reset (rst_n low, synchronous) loads register defaults, clears state, sum, count, valid.
module windowed_rms_meter #(
  parameter int SAMPLE_BITS = wrms_pkg::DEF_SAMPLE_BITS,
  parameter int MAX_WINDOW  = wrms_pkg::DEF_MAX_WINDOW,
  parameter int FRAC_BITS   = wrms_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  wrms_in_if.sink                      in_ch,
  wrms_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [wrms_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [wrms_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [wrms_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import wrms_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;
  logic    out_valid;
  logic    out_gated;
  logic [RMS_W-1:0] out_rms_value;

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.rms_value = out_rms_value;
  assign out_ch.gated     = out_gated;

  wrms_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  wrms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wrms_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .in_sample     (in_ch.sample),
    .out_ready     (out_ch.ready),
    .out_valid     (out_valid),
    .out_rms_value (out_rms_value),
    .out_gated     (out_gated)
  );

endmodule

/* hw/rtl/wrms_cfg.sv */
// APB register file of the windowed RMS meter, 64-bit data, registers at 8*index.
// Depends on wrms_pkg.
module wrms_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wrms_pkg::CFG_AW-1:0]  paddr,
  input  logic [wrms_pkg::CFG_DW-1:0]  pwdata,
  output logic [wrms_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output wrms_pkg::cfg_t               cfg
);
  import wrms_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MODE:   cfg_nxt.mode           = pwdata[0];
        REG_WINDOW: cfg_nxt.window_length  = pwdata[WLEN_W-1:0];
        REG_OFFSET: cfg_nxt.offset_counts  = pwdata[OFFS_W-1:0];
        REG_GATE:   cfg_nxt.gate_threshold = pwdata[SUM_W-1:0];
        REG_ADD:    cfg_nxt.post_root_add  = pwdata[ADD_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = CFG_DW'(cfg_r.mode);
      REG_WINDOW: prdata = CFG_DW'(cfg_r.window_length);
      REG_OFFSET: prdata = CFG_DW'(cfg_r.offset_counts);
      REG_GATE:   prdata = CFG_DW'(cfg_r.gate_threshold);
      REG_ADD:    prdata = CFG_DW'(cfg_r.post_root_add);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode           <= 1'b0;
      cfg_r.window_length  <= WLEN_RESET;
      cfg_r.offset_counts  <= '0;
      cfg_r.gate_threshold <= '0;
      cfg_r.post_root_add  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hw/rtl/wrms_ctrl.sv */
// Sequencer of the windowed RMS meter: steps the datapath through
// square, accumulate, divide, root and result. Depends on wrms_pkg.
module wrms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wrms_pkg::dp_sts_t sts,
  output wrms_pkg::dp_cmd_t cmd
);
  import wrms_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQR   = 7'b0000010,
    S_ACC   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_RLOAD = 7'b0010000,
    S_ROOT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        cmd.square = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        if (sts.win_end) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_RLOAD;
      end
      S_RLOAD: begin
        cmd.root_init = 1'b1;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_acc_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |=> state_r == S_IDLE || state_r == S_DIV)
    else $error("accumulate step left to an unexpected state");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result issued while output register busy");
  a_div_to_root: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && sts.div_last |=> state_r == S_RLOAD)
    else $error("divide did not hand over to root");

endmodule

/* hw/rtl/wrms_dp.sv */
// Datapath of the windowed RMS meter: offset, square, saturating sum,
// bit-serial divider, digit-by-digit root, output register. Depends on wrms_pkg.
module wrms_dp #(
  parameter int SAMPLE_BITS = wrms_pkg::DEF_SAMPLE_BITS,
  parameter int MAX_WINDOW  = wrms_pkg::DEF_MAX_WINDOW,
  parameter int FRAC_BITS   = wrms_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wrms_pkg::cfg_t                cfg,
  input  wrms_pkg::dp_cmd_t             cmd,
  output wrms_pkg::dp_sts_t             sts,
  input  logic [wrms_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [wrms_pkg::RMS_W-1:0]    out_rms_value,
  output logic                          out_gated
);
  import wrms_pkg::*;

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int DIV_W = SUM_W + 2 * FRAC_BITS;
  localparam int QX_W  = (DIV_W > MEAN_W) ? DIV_W : MEAN_W;
  localparam int IT_W  = $clog2(DIV_W);

  logic signed [SAMPLE_BITS-1:0] s_low;
  logic signed [DIFF_W-1:0]      x, offs, diff;
  logic [MAG_W-1:0]              mag_r, mag_nxt;
  logic [PROD_W-1:0]             prod_r, prod_nxt;
  logic [SUM_W:0]                sum_ext;
  logic [SUM_W-1:0]              sum_acc, sum_r, sum_nxt;
  logic [WLEN_W-1:0]             count_inc, count_r, count_nxt;
  logic [WIN_W-1:0]              win_eff;
  logic [DIV_W-1:0]              dq_r, dq_nxt;
  logic [WIN_W-1:0]              drem_r, drem_nxt;
  logic [WIN_W:0]                drem_sh, win_ext;
  logic                          q_bit;
  logic [QX_W-1:0]               qx;
  logic [MEAN_W-1:0]             mean;
  logic [MEAN_W-1:0]             rad_r, rad_nxt;
  logic [ROOT_W-1:0]             rrem_r, rrem_nxt, root_r, root_nxt;
  logic [ROOT_W+1:0]             rrem_sh, trial;
  logic                          r_bit;
  logic [IT_W-1:0]               iter_r, iter_nxt;
  logic                          gate_hit;
  logic [ROOT_W:0]               add_sum;
  logic [RMS_W-1:0]              rms_sat;
  logic                          out_valid_r, out_valid_nxt;
  logic [RMS_W-1:0]              out_rms_r, out_rms_nxt;
  logic                          out_gated_r, out_gated_nxt;

  // sample conditioning
  assign s_low   = in_sample[SAMPLE_BITS-1:0];
  assign x       = DIFF_W'(s_low);
  assign offs    = DIFF_W'($signed(cfg.offset_counts));
  assign diff    = cfg.mode ? x : x - offs;
  assign mag_nxt = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(prod_r);
  assign sum_acc = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

  always_comb begin
    if (cfg.window_length == '0)
      win_eff = WIN_W'(1);
    else if (32'(cfg.window_length) > 32'(MAX_WINDOW))
      win_eff = WIN_W'(MAX_WINDOW);
    else
      win_eff = WIN_W'(cfg.window_length);
  end

  assign count_inc = count_r + 1'b1;

  // restoring divider, one quotient bit per cycle
  assign win_ext  = {1'b0, win_eff};
  assign drem_sh  = {drem_r, dq_r[DIV_W-1]};
  assign q_bit    = (drem_sh >= win_ext);
  assign qx       = QX_W'(dq_r);
  assign mean     = ((qx >> MEAN_W) != '0) ? {MEAN_W{1'b1}} : qx[MEAN_W-1:0];

  // square root, two radicand bits per cycle
  assign rrem_sh = {rrem_r, rad_r[MEAN_W-1 -: 2]};
  assign trial   = {root_r, 2'b01};
  assign r_bit   = (rrem_sh >= trial);

  assign gate_hit = cfg.mode && (sum_r <= cfg.gate_threshold);
  assign add_sum  = (ROOT_W + 1)'(root_r) +
                    (cfg.mode ? (ROOT_W + 1)'(cfg.post_root_add) : '0);
  assign rms_sat  = (add_sum > (ROOT_W + 1)'(RMS_MAX)) ? RMS_MAX : add_sum[RMS_W-1:0];

  assign sts.win_end   = (count_inc == '0) || (32'(count_inc) >= 32'(win_eff));
  assign sts.div_last  = (iter_r == IT_W'(DIV_W - 1));
  assign sts.root_last = (iter_r == IT_W'(ROOT_W - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_rms_value = out_rms_r;
  assign out_gated     = out_gated_r;

  always_comb begin
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    dq_nxt        = dq_r;
    drem_nxt      = drem_r;
    rad_nxt       = rad_r;
    rrem_nxt      = rrem_r;
    root_nxt      = root_r;
    iter_nxt      = iter_r;
    prod_nxt      = prod_r;
    out_rms_nxt   = out_rms_r;
    out_gated_nxt = out_gated_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (cmd.square) prod_nxt = mag_r * mag_r;
    if (cmd.accum) begin
      sum_nxt   = sum_acc;
      count_nxt = count_inc;
    end
    if (cmd.div_init) begin
      dq_nxt   = DIV_W'(sum_acc) << (2 * FRAC_BITS);
      drem_nxt = '0;
      iter_nxt = '0;
    end
    if (cmd.div_step) begin
      dq_nxt   = {dq_r[DIV_W-2:0], q_bit};
      drem_nxt = q_bit ? WIN_W'(drem_sh - win_ext) : drem_sh[WIN_W-1:0];
      iter_nxt = iter_r + 1'b1;
    end
    if (cmd.root_init) begin
      rad_nxt  = mean;
      rrem_nxt = '0;
      root_nxt = '0;
      iter_nxt = '0;
    end
    if (cmd.root_step) begin
      rad_nxt  = rad_r << 2;
      rrem_nxt = r_bit ? ROOT_W'(rrem_sh - trial) : rrem_sh[ROOT_W-1:0];
      root_nxt = {root_r[ROOT_W-2:0], r_bit};
      iter_nxt = iter_r + 1'b1;
    end
    if (cmd.emit) begin
      sum_nxt       = '0;
      count_nxt     = '0;
      out_valid_nxt = 1'b1;
      out_rms_nxt   = gate_hit ? '0 : rms_sat;
      out_gated_nxt = gate_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mag_r <= mag_nxt;
    prod_r      <= prod_nxt;
    dq_r        <= dq_nxt;
    drem_r      <= drem_nxt;
    rad_r       <= rad_nxt;
    rrem_r      <= rrem_nxt;
    root_r      <= root_nxt;
    out_rms_r   <= out_rms_nxt;
    out_gated_r <= out_gated_nxt;
  end

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> sum_r == '0 && count_r == '0)
    else $error("window state not cleared after result");
  a_gated_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_gated_r |-> out_rms_r == '0)
    else $error("gated result carries a nonzero value");
  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accum && !sts.win_end |=> 32'(count_r) < 32'(win_eff))
    else $error("sample count passed window without closing it");

endmodule

/* dv/tb_windowed_rms_meter.sv */
// Self-checking testbench for windowed_rms_meter: drives samples and register writes,
// predicts every RMS result in-line and checks each one as it leaves the block.
// Depends on wrms_pkg, wrms_if and the RTL of windowed_rms_meter.
module tb_windowed_rms_meter;
  timeunit 1ns;
  timeprecision 1ps;
  import wrms_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 128;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 680;
  localparam int BURST_ITEMS   = 96;
  localparam int IDLE_PCT      = 27;
  localparam int REG_STRIDE    = 8;
  localparam int UNMAPPED_REG  = 5;
  localparam int FULL_WINDOW   = DEF_MAX_WINDOW;

  localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [ADD_W-1:0]    ADD_MAX    = '1;

  typedef struct packed {
    logic [RMS_W-1:0] rms_value;
    logic             gated;
  } meter_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  wrms_in_if  in_ch();
  wrms_out_if out_ch();

  windowed_rms_meter i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // predicted register file and accumulator
  logic              cur_mode;
  logic [WLEN_W-1:0] win_len;
  logic [OFFS_W-1:0] offs;
  logic [SUM_W-1:0]  gate_thr;
  logic [ADD_W-1:0]  root_add;
  longint unsigned   acc_sum;
  logic [WLEN_W-1:0] acc_count;

  meter_result_t rms_expected[$];
  int mismatches   = 0;
  int quiet_cycles = 0;
  int idle_pct     = IDLE_PCT;
  int stall_pct    = IDLE_PCT;

  function automatic longint unsigned mean_scaled(input longint unsigned total,
                                                  input longint unsigned n);
    longint unsigned q, r;
    q = total / n;
    r = total % n;
    for (int i = 0; i < 2 * DEF_FRAC_BITS; i++) begin
      if (q[63]) return '1;
      q = q << 1;
      r = r << 1;
      if (r >= n) begin
        r = r - n;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void store_reg(input int idx, input logic [CFG_DW-1:0] v);
    case (idx)
      REG_MODE:   cur_mode = v[0];
      REG_WINDOW: win_len  = v[WLEN_W-1:0];
      REG_OFFSET: offs     = v[OFFS_W-1:0];
      REG_GATE:   gate_thr = v[SUM_W-1:0];
      REG_ADD:    root_add = v[ADD_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void absorb_sample(input logic [SAMPLE_W-1:0] raw);
    longint diff;
    longint unsigned mag, sq, span, root, level;
    meter_result_t res;
    diff = longint'($signed(raw));
    if (!cur_mode) diff = diff - longint'($signed(offs));
    mag = (diff < 0) ? -diff : diff;
    sq = mag * mag;
    acc_sum = (sq > SUM_LIMIT - acc_sum) ? SUM_LIMIT : acc_sum + sq;
    span = win_len;
    if (span == 0) span = 1;
    if (span > FULL_WINDOW) span = FULL_WINDOW;
    acc_count = acc_count + 1'b1;
    if (acc_count != 0 && acc_count < span) return;
    root = int_sqrt(mean_scaled(acc_sum, span));
    res.gated = 1'b0;
    if (cur_mode && acc_sum <= gate_thr) begin
      level = 0;
      res.gated = 1'b1;
    end else if (cur_mode) begin
      level = root + root_add;
    end else begin
      level = root;
    end
    res.rms_value = (level > RMS_MAX) ? RMS_MAX : level[RMS_W-1:0];
    rms_expected.push_back(res);
    acc_sum = 0;
    acc_count = '0;
  endfunction

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    meter_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rms_expected.size() == 0) begin
        $display("%0t: unexpected result rms_value=%0d gated=%0d",
                 $time, out_ch.rms_value, out_ch.gated);
        mismatches++;
      end else begin
        want = rms_expected.pop_front();
        if (out_ch.rms_value !== want.rms_value) begin
          $display("%0t: rms_value expected %0d actual %0d",
                   $time, want.rms_value, out_ch.rms_value);
          mismatches++;
        end
        if (out_ch.gated !== want.gated) begin
          $display("%0t: gated expected %0d actual %0d", $time, want.gated, out_ch.gated);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    absorb_sample(s);
  endtask

  // drain: stop sending, wait for all results, then let the window-end pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (rms_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(idx * REG_STRIDE);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    store_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DW-1:0] with_junk(input logic [CFG_DW-1:0] v, input int width);
    logic [CFG_DW-1:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) return v;
    return v | (junk << width);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [WLEN_W-1:0] pick_window();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2, 3, 4, 5: return WLEN_W'($urandom_range(1, 8));
      6, 7, 8: return WLEN_W'($urandom_range(9, 32));
      default: return WLEN_W'($urandom_range(33, 200));
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] pick_threshold();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return SUM_W'(SUM_LIMIT);
      default: return SUM_W'(({$urandom, $urandom} & SUM_LIMIT) >> $urandom_range(9, 30));
    endcase
  endfunction

  function automatic logic [ADD_W-1:0] pick_add();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return ADD_MAX;
      2: return ADD_W'($urandom_range(0, 1023));
      default: return ADD_W'($urandom);
    endcase
  endfunction

  task automatic test_current_mode_extremes();
    write_reg(REG_MODE, '0);
    write_reg(REG_WINDOW, 64'd1);
    write_reg(REG_OFFSET, '0);
    write_reg(REG_GATE, '0);
    write_reg(REG_ADD, '0);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample('0);
    push_sample('1);
    settle();
    write_reg(REG_OFFSET, CFG_DW'(SAMPLE_MIN));
    push_sample(SAMPLE_MAX);
    settle();
    write_reg(REG_OFFSET, CFG_DW'(SAMPLE_MAX));
    push_sample(SAMPLE_MIN);
    settle();
    // add and gate have no effect in current mode
    write_reg(REG_ADD, CFG_DW'(ADD_MAX));
    write_reg(REG_GATE, SUM_LIMIT);
    push_sample(SAMPLE_W'(12345));
  endtask

  task automatic test_window_limits();
    settle();
    write_reg(REG_WINDOW, 64'hFFFF_FFFF_FFFF_E000);
    push_sample(SAMPLE_W'(-777));
    push_sample(SAMPLE_MAX);
  endtask

  task automatic test_voltage_gate();
    settle();
    write_reg(REG_MODE, 64'h3);
    write_reg(REG_WINDOW, 64'd1);
    write_reg(REG_GATE, 64'd10000);
    write_reg(REG_ADD, '0);
    push_sample(SAMPLE_W'(100));
    push_sample(SAMPLE_W'(-100));
    settle();
    write_reg(REG_GATE, 64'd9999);
    push_sample(SAMPLE_W'(100));
    settle();
    write_reg(REG_ADD, CFG_DW'(ADD_MAX));
    write_reg(REG_GATE, '0);
    push_sample(SAMPLE_MAX);
    push_sample('0);
  endtask

  task automatic test_mid_window_changes();
    settle();
    write_reg(REG_MODE, '0);
    write_reg(REG_OFFSET, '0);
    write_reg(REG_WINDOW, 64'd8);
    for (int i = 0; i < 5; i++) push_sample(pick_sample());
    settle();
    write_reg(REG_WINDOW, 64'd3);
    push_sample(pick_sample());
    settle();
    write_reg(REG_WINDOW, 64'd4);
    write_reg(REG_OFFSET, 64'd1000);
    push_sample(SAMPLE_W'(3000));
    push_sample(SAMPLE_W'(-3000));
    settle();
    write_reg(REG_MODE, 64'd1);
    write_reg(REG_GATE, '0);
    write_reg(REG_ADD, 64'd512);
    write_reg(UNMAPPED_REG, '1);
    push_sample(SAMPLE_W'(3000));
    push_sample(SAMPLE_W'(-3000));
  endtask

  // no idling on either side, largest and zero squares alternating back to back over several windows
  task automatic test_back_to_back();
    settle();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(REG_MODE, '0);
    write_reg(REG_OFFSET, CFG_DW'(SAMPLE_MAX));
    write_reg(REG_WINDOW, 64'd32);
    for (int i = 0; i < BURST_ITEMS; i++) push_sample(i[0] ? SAMPLE_MAX : SAMPLE_MIN);
    settle();
    idle_pct  = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  task automatic test_random_windows();
    int sent, phase_len, split;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      write_reg(REG_MODE, with_junk(CFG_DW'($urandom_range(0, 1)), 1));
      write_reg(REG_WINDOW, with_junk(CFG_DW'(pick_window()), WLEN_W));
      write_reg(REG_OFFSET, with_junk(CFG_DW'(pick_sample()), OFFS_W));
      write_reg(REG_GATE, with_junk(CFG_DW'(pick_threshold()), SUM_W));
      write_reg(REG_ADD, with_junk(CFG_DW'(pick_add()), ADD_W));
      phase_len = $urandom_range(10, 60);
      split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, phase_len - 1) : phase_len;
      for (int i = 0; i < phase_len; i++) begin
        if (i == split) begin
          settle();
          case ($urandom_range(0, 2))
            0: write_reg(REG_WINDOW, CFG_DW'(pick_window()));
            1: write_reg(REG_MODE, CFG_DW'(~cur_mode));
            default: write_reg(REG_OFFSET, CFG_DW'(pick_sample()));
          endcase
        end
        push_sample(pick_sample());
      end
      sent += phase_len;
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    cur_mode  = 1'b0;
    win_len   = WLEN_RESET;
    offs      = '0;
    gate_thr  = '0;
    root_add  = '0;
    acc_sum   = 0;
    acc_count = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_current_mode_extremes();
    test_window_limits();
    test_voltage_gate();
    test_mid_window_changes();
    test_back_to_back();
    test_random_windows();
    settle();

    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/wrms_pkg.sv
hw/rtl/wrms_if.sv
hw/rtl/wrms_cfg.sv
hw/rtl/wrms_ctrl.sv
hw/rtl/wrms_dp.sv
hw/rtl/windowed_rms_meter.sv
dv/tb_windowed_rms_meter.sv
